// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the permutation ranker.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Combinational check, sampled at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Next-cycle implication, sampled at every rising edge outside reset.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/prank_pkg.sv
// Types and constants of the permutation ranker.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
`timescale 1ns / 1ps

package prank_pkg;

  localparam int ELEM_W     = 5;
  localparam int RANK_W     = 62;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef logic [ELEM_W-1:0]     elem_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERM_LENGTH = 1'b0,
    REG_EVEN_PARITY = 1'b1
  } cfg_reg_t;

endpackage

// File: rtl/prank_in_if.sv
// Input channel of the permutation ranker: one permutation element per item.
// Depends on prank_pkg.
`timescale 1ns / 1ps

interface prank_in_if import prank_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// File: rtl/prank_out_if.sv
// Result channel of the permutation ranker: one rank per completed permutation.
// Depends on prank_pkg.
`timescale 1ns / 1ps

interface prank_out_if import prank_pkg::*; ();
  logic  valid;
  logic  ready;
  rank_t rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

// File: rtl/prank_cfg_if.sv
// Configuration write channel of the permutation ranker.
// Depends on prank_pkg.
`timescale 1ns / 1ps

interface prank_cfg_if import prank_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_reg_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/permutation_rank_top.sv
// Streamed swap-based (mixed-radix) ranking of a permutation of 0..n-1.
// Depends on prank_pkg, prank_in_if, prank_out_if, prank_cfg_if, assert_macros.svh.
//
//   channel  | dir | payload                 | handshake
//   ---------+-----+-------------------------+------------------------------
//   in_ch    | in  | element  (5 b)          | valid/ready, one item per cycle unless stalled
//   out_ch   | out | rank     (62 b)         | valid/ready, one per permutation
//   cfg_ch   | in  | index (1 b), data (5 b) | valid/ready, ready always high
//
// Each item waits in the input register, where the table swap, the 62x5 rank
// and radix products and the rank add complete, so the block sustains one
// item per clock unless stalled. The rank leaves the output register in the
// cycle after the completing item. Reset (rst_n low, synchronous) restores
// identity tables and default registers. A result waiting in the output
// register stalls only the item that would complete the next permutation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module permutation_rank_top import prank_pkg::*; #(
  parameter int MAX_ELEMENTS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  prank_in_if.sink    in_ch,
  prank_out_if.source out_ch,
  prank_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Configuration: keep the clamped length, not the raw register value
  cnt_t n_eff_r;
  logic even_r;

  // Input register
  logic  item_v_r;
  elem_t item_r;

  // Ranking state
  idx_t  arrangement_r [MAX_ELEMENTS];
  idx_t  position_r    [MAX_ELEMENTS];
  idx_t  arrangement_nxt [MAX_ELEMENTS];
  idx_t  position_nxt    [MAX_ELEMENTS];
  rank_t rank_r, rank_nxt;
  rank_t radix_r, radix_nxt;
  cnt_t  count_r, count_nxt;

  // Output register
  logic  out_v_r;
  rank_t out_rank_r;

  // Datapath
  idx_t                  e_idx, i_idx, j_idx, a_idx, mag;
  logic                  neg;
  logic                  counted, done, fire;
  logic [CNT_W:0]        count_inc;
  logic [CNT_W:0]        reach;
  cnt_t                  factor;
  logic [RANK_W+IDX_W-1:0] term_full;
  logic [RANK_W+CNT_W-1:0] radix_full;
  rank_t                 term;
  cfg_data_t             len_in;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;
  assign len_in       = cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r <= cnt_t'(MAX_ELEMENTS);
      even_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PERM_LENGTH: begin
          // Length zero counts as one; clip at the table size
          if (len_in == '0) begin
            n_eff_r <= cnt_t'(1);
          end else if (len_in > CFG_DATA_W'(MAX_ELEMENTS)) begin
            n_eff_r <= cnt_t'(MAX_ELEMENTS);
          end else begin
            n_eff_r <= cnt_t'(len_in);
          end
        end
        REG_EVEN_PARITY: even_r <= len_in[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  // Only the completing item needs a free output slot.
  assign fire        = item_v_r && (!done || !out_v_r || out_ch.ready);
  assign in_ch.ready = !item_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.element;
    end
  end

  // ------------------------------------------------------------- datapath
  always_comb begin
    // Fold elements past the table onto its last entry
    if (item_r >= ELEM_W'(MAX_ELEMENTS)) begin
      e_idx = idx_t'(MAX_ELEMENTS - 1);
    end else begin
      e_idx = item_r[IDX_W-1:0];
    end
    i_idx = count_r[IDX_W-1:0];
    j_idx = position_r[e_idx];
    a_idx = arrangement_r[i_idx];

    count_inc = {1'b0, count_r} + (CNT_W+1)'(1);
    reach     = {1'b0, count_r} + (even_r ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    counted   = reach < {1'b0, n_eff_r};
    done      = count_inc >= {1'b0, n_eff_r};

    // rank += radix * (j - i), done as add or subtract of radix * |j - i|
    neg        = j_idx < i_idx;
    mag        = neg ? (i_idx - j_idx) : (j_idx - i_idx);
    term_full  = radix_r * mag;
    term       = term_full[RANK_W-1:0];
    factor     = n_eff_r - count_r;
    radix_full = radix_r * factor;

    rank_nxt  = rank_r;
    radix_nxt = radix_r;
    count_nxt = count_r;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      arrangement_nxt[k] = arrangement_r[k];
      position_nxt[k]    = position_r[k];
    end

    if (fire) begin
      count_nxt = count_inc[CNT_W-1:0];
      if (counted) begin
        rank_nxt  = neg ? (rank_r - term) : (rank_r + term);
        radix_nxt = radix_full[RANK_W-1:0];
        // Swap: slot i takes the element, slot j takes what stood at i
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
          if (idx_t'(k) == i_idx) begin
            arrangement_nxt[k] = e_idx;
          end else if (idx_t'(k) == j_idx) begin
            arrangement_nxt[k] = a_idx;
          end
          if (idx_t'(k) == e_idx) begin
            position_nxt[k] = i_idx;
          end else if (idx_t'(k) == a_idx) begin
            position_nxt[k] = j_idx;
          end
        end
      end
      if (done) begin
        // Permutation complete: back to identity for the next one
        rank_nxt  = '0;
        radix_nxt = rank_t'(1);
        count_nxt = '0;
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
          arrangement_nxt[k] = idx_t'(k);
          position_nxt[k]    = idx_t'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= '0;
      radix_r <= rank_t'(1);
      count_r <= '0;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        arrangement_r[k] <= idx_t'(k);
        position_r[k]    <= idx_t'(k);
      end
    end else begin
      rank_r  <= rank_nxt;
      radix_r <= radix_nxt;
      count_r <= count_nxt;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        arrangement_r[k] <= arrangement_nxt[k];
        position_r[k]    <= position_nxt[k];
      end
    end
  end

  // -------------------------------------------------------- output register
  // The completing step is never counted, so the stored rank is final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && done) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && done) begin
      out_rank_r <= rank_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.rank  = out_rank_r;

  // ------------------------------------------------------------ assertions
  `ASSERT_ALWAYS(a_tables_inverse, position_r[arrangement_r[0]] == '0, "tables not inverse")
  `ASSERT_NEXT(a_done_gives_result, fire && done, out_v_r, "completed item left no result")
  `ASSERT_NEXT(a_done_clears, fire && done, count_r == '0 && radix_r == rank_t'(1), "state not cleared after completion")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for permutation_rank_top: streams permutations, predicts each rank.
// Depends on prank_pkg, prank_in_if, prank_out_if, prank_cfg_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import prank_pkg::*;

  localparam int MAX_ELEMENTS = 20;
  localparam int SETTLE       = 8;       // cycles to let an item with no rank clear the block
  localparam int ITEM_TARGET  = 1200;
  localparam int HOLD_PHASE   = 2;       // random phase that gets the long receiver hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;

  logic clk   = 1'b1;
  logic rst_n = 1'b0;

  prank_in_if  in_ch ();
  prank_out_if out_ch ();
  prank_cfg_if cfg_ch ();

  permutation_rank_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b0;
    #10 clk = 1'b1;
  end

  // Predictor state: working arrangement, its inverse and the mixed-radix sums.
  elem_t             layout  [MAX_ELEMENTS];
  elem_t             slot_of [MAX_ELEMENTS];
  rank_t             rank_sum;
  rank_t             radix;
  logic [ELEM_W-1:0] seen_count;
  cfg_data_t         len_reg;
  logic              parity_reg;

  elem_t element_q [$];   // elements waiting for the driver
  rank_t rank_q    [$];   // ranks predicted but not yet seen on the output

  bit in_took;            // input item accepted at the last rising edge
  int hold_req;           // long hold-off requests from the stimulus
  int hold_seen;          // requests the receiver has taken up
  int burst_left, gap_left;
  int hold_left, mode, mode_left;
  logic [7:0] stall_pat = 8'b1011_0010;

  int fails, elements_in, ranks_out, settings_used, cycles;

  function automatic void clear_tables();
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      layout[k]  = elem_t'(k);
      slot_of[k] = elem_t'(k);
    end
    rank_sum   = '0;
    radix      = rank_t'(1);
    seen_count = '0;
  endfunction

  // Advance the ranking by one element; return 1 with the rank when a permutation closes.
  function automatic bit rank_step(input elem_t el, output rank_t rank_out);
    int n, i, skip, e, j, a;
    longint diff;
    logic [63:0] acc;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    i    = seen_count;
    skip = parity_reg ? 2 : 1;
    e    = el;
    if (e >= MAX_ELEMENTS) e = MAX_ELEMENTS - 1;
    rank_out = '0;
    if (i < MAX_ELEMENTS && i + skip < n) begin
      j    = slot_of[e];
      a    = layout[i];
      diff = longint'(j) - longint'(i);
      layout[j]  = elem_t'(a);
      slot_of[a] = elem_t'(j);
      layout[i]  = elem_t'(e);
      slot_of[e] = elem_t'(i);
      acc      = 64'(rank_sum) + 64'(radix) * 64'(diff);
      rank_sum = acc[RANK_W-1:0];
      acc      = 64'(radix) * 64'(n - i);
      radix    = acc[RANK_W-1:0];
    end
    seen_count = ELEM_W'(i + 1);
    if (seen_count >= n) begin
      rank_out = rank_sum;
      clear_tables();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Driver: present queued elements in bursts with random gaps, hold until accepted.
  always @(negedge clk) begin : drive_elements
    logic  nv;
    elem_t ne;
    nv = in_ch.valid;
    ne = in_ch.element;
    if (!rst_n) begin
      nv = 1'b0;
      ne = '0;
    end else if (!in_ch.valid || in_took) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (element_q.size() != 0) begin
        ne = element_q.pop_front();
        nv = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_ch.valid   <= nv;
    in_ch.element <= ne;
  end

  // Receiver: switch between stall patterns; a hold-off overrides them all.
  always @(negedge clk) begin : drive_ready
    logic r;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
      stall_pat = 8'($urandom_range(1, 255));
    end else begin
      mode_left--;
    end
    case (mode)
      0: r = 1'b1;
      1: r = ($urandom_range(0, 3) != 0);
      2: begin
        r         = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      default: r = ($urandom_range(0, 2) == 0);
    endcase
    if (hold_left > 0) begin
      r = 1'b0;
      hold_left--;
    end
    out_ch.ready <= r;
  end

  // Monitor: apply register writes and accepted elements to the predictor, check each rank.
  always @(posedge clk) begin : watch_channels
    rank_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        ranks_out++;
        if (rank_q.size() == 0) begin
          $error("unexpected rank item: actual %0d", out_ch.rank);
          fails++;
        end else begin
          want = rank_q.pop_front();
          if (out_ch.rank !== want) begin
            $error("field rank: expected %0d, actual %0d", want, out_ch.rank);
            fails++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PERM_LENGTH: len_reg    = cfg_ch.data;
          REG_EVEN_PARITY: parity_reg = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        elements_in++;
        if (rank_step(in_ch.element, want)) rank_q.push_back(want);
      end
    end
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every element is taken and every rank is out, then let the pipeline empty.
  task automatic drain();
    while (element_q.size() != 0 || in_ch.valid || rank_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input cfg_data_t len, input cfg_data_t par);
    settings_used++;
    write_reg(REG_PERM_LENGTH, len);
    write_reg(REG_EVEN_PARITY, par);
  endtask

  initial begin : stimulus
    elem_t     perm [MAX_ELEMENTS];
    elem_t     tmp;
    cfg_data_t len, par;
    int        n, k, m, pick, perms, flavor, items_made, phase;

    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_PERM_LENGTH;
    cfg_ch.data   = '0;
    len_reg       = cfg_data_t'(MAX_ELEMENTS);
    parity_reg    = 1'b0;
    clear_tables();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero length acts as one; every element closes a permutation, out-of-table element too.
    configure(5'd0, 5'b11111);
    element_q = '{5'd0, 5'd31};
    drain();

    // Invalid permutation: elements not below n and a repeat.
    configure(5'd4, 5'b00000);
    element_q = '{5'd19, 5'd16, 5'd0, 5'd19};
    drain();

    // Even-parity mode on a short valid permutation, then one with nothing counted.
    configure(5'd3, 5'b00001);
    element_q = '{5'd2, 5'd1, 5'd0};
    drain();
    configure(5'd2, 5'b00011);
    element_q = '{5'd1, 5'd0};
    drain();

    // Length lowered mid-permutation: the next element closes it.
    configure(5'd5, 5'b00000);
    element_q = '{5'd4, 5'd0};
    drain();
    configure(5'd2, 5'b00000);
    element_q = '{5'd1};
    drain();

    items_made = 0;
    phase      = 0;
    while (items_made < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (phase == HOLD_PHASE)  len = 5'd1;
      else if (pick < 12)       len = cfg_data_t'($urandom_range(2, 6));
      else if (pick < 15)       len = cfg_data_t'($urandom_range(7, 12));
      else if (pick < 17)       len = cfg_data_t'(MAX_ELEMENTS);
      else if (pick == 17)      len = cfg_data_t'($urandom_range(0, 1));
      else if (pick == 18)      len = cfg_data_t'($urandom_range(21, 31));
      else                      len = cfg_data_t'($urandom_range(13, 19));
      par = cfg_data_t'($urandom_range(0, 31));
      configure(len, par);
      n = (len == 0) ? 1 : ((len > MAX_ELEMENTS) ? MAX_ELEMENTS : len);
      perms = (n == 1) ? 80 : $urandom_range(3, 2 + 120 / n);
      if (phase == HOLD_PHASE) hold_req++;

      for (int p = 0; p < perms; p++) begin
        for (k = 0; k < n; k++) perm[k] = elem_t'(k);
        for (k = n - 1; k > 0; k--) begin
          m       = $urandom_range(0, k);
          tmp     = perm[k];
          perm[k] = perm[m];
          perm[m] = tmp;
        end
        // Mostly well-formed; some noise and some with a repeated element.
        flavor = $urandom_range(0, 9);
        if (flavor == 0) begin
          for (k = 0; k < n; k++) perm[k] = elem_t'($urandom_range(0, 31));
        end else if (flavor == 1 && n > 1) begin
          k       = $urandom_range(0, n - 1);
          m       = $urandom_range(0, n - 1);
          perm[k] = perm[m];
        end
        for (k = 0; k < n; k++) element_q.push_back(perm[k]);
        items_made += n;
      end
      // Leave a permutation open now and then so the next setting lands mid-stream.
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        m = $urandom_range(1, n - 1);
        for (k = 0; k < m; k++) element_q.push_back(elem_t'($urandom_range(0, n - 1)));
        items_made += m;
      end
      drain();
      phase++;
    end

    $display("Streamed %0d elements under %0d register settings; %0d ranks compared.",
             elements_in, settings_used, ranks_out);
    $display("Covered length clamps, even-parity mode, broken permutations and a long stall.");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
